// ===== rtl/lfsd_pkg.sv =====
// ----------------------------------------------------------------------------
// lfsd_pkg
// shared constants, sensor codes and the full-step coil table for the
// line follower stepper drive
// ----------------------------------------------------------------------------
package lfsd_pkg;

    // field widths
    localparam int SENSOR_W    = 5;
    localparam int COIL_W      = 4;
    localparam int PERIOD_W    = 16;
    localparam int PHASE_W     = 2;
    localparam int CFG_INDEX_W = 1;

    // parameter defaults
    localparam int PHASE_COUNT = 4;
    localparam int COUNT_WIDTH = 16;

    // register reset values
    localparam logic [PERIOD_W-1:0] FAST_PERIOD_RST = 16'd196;
    localparam logic [PERIOD_W-1:0] SLOW_PERIOD_RST = 16'd391;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_FAST_PERIOD = 1'b0,
        CFG_SLOW_PERIOD = 1'b1
    } t_cfg_index;

    // line sensor codes
    localparam logic [SENSOR_W-1:0] PAT_LEFT_HARD_A  = 5'b00011;
    localparam logic [SENSOR_W-1:0] PAT_LEFT_HARD_B  = 5'b00001;
    localparam logic [SENSOR_W-1:0] PAT_LEFT_SOFT_A  = 5'b00110;
    localparam logic [SENSOR_W-1:0] PAT_LEFT_SOFT_B  = 5'b00010;
    localparam logic [SENSOR_W-1:0] PAT_CENTER       = 5'b00100;
    localparam logic [SENSOR_W-1:0] PAT_RIGHT_SOFT_A = 5'b01100;
    localparam logic [SENSOR_W-1:0] PAT_RIGHT_SOFT_B = 5'b01000;
    localparam logic [SENSOR_W-1:0] PAT_RIGHT_HARD_A = 5'b11000;
    localparam logic [SENSOR_W-1:0] PAT_RIGHT_HARD_B = 5'b10000;

    // coil patterns
    localparam logic [COIL_W-1:0] COIL_OFF = 4'b0000;
    localparam logic [COIL_W-1:0] COIL_PH0 = 4'b0101;
    localparam logic [COIL_W-1:0] COIL_PH1 = 4'b0110;
    localparam logic [COIL_W-1:0] COIL_PH2 = 4'b1010;
    localparam logic [COIL_W-1:0] COIL_PH3 = 4'b1001;

    // full-step coil table
    function automatic logic [COIL_W-1:0] coil_of(input logic [PHASE_W-1:0] phase);
        logic [COIL_W-1:0] coil;
        case (phase)
            2'd0:    coil = COIL_PH0;
            2'd1:    coil = COIL_PH1;
            2'd2:    coil = COIL_PH2;
            default: coil = COIL_PH3;
        endcase
        return coil;
    endfunction

    // decoded motor command for one tick
    typedef struct packed {
        logic right_en;
        logic left_en;
        logic right_slow;
        logic left_slow;
    } t_motor_cmd;

endpackage

// ===== rtl/line_follower_stepper_drive.sv =====
// ----------------------------------------------------------------------------
// line_follower_stepper_drive
// decodes line sensor words into two full-step stepper coil drives
// ----------------------------------------------------------------------------
// Each input word is one timer tick with the 5-bit sensor pattern. The block
// takes one word per clock cycle unless a waiting coil word stalls it: the sensor
// decode, both tick counters, the period compares and the phase steps sit in one
// short combinational pass that writes the state and the coil output registers at
// the accept edge. The output register doubles as the coil drive state, so a new
// word is taken whenever the output is empty or being taken in the same cycle. The
// configuration port is always ready; the user must write periods while the block
// is idle, which the block itself does not enforce. A period of zero steps an
// enabled motor every tick, and a period the counter cannot reach stops stepping.
// ----------------------------------------------------------------------------
module line_follower_stepper_drive #(
    parameter int COUNT_WIDTH = lfsd_pkg::COUNT_WIDTH
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // sensor words
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [lfsd_pkg::SENSOR_W-1:0]      i_sensor_pattern,
    // coil words
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [lfsd_pkg::COIL_W-1:0]        o_right_coils,
    output logic [lfsd_pkg::COIL_W-1:0]        o_left_coils,
    // configuration writes
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [lfsd_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [lfsd_pkg::PERIOD_W-1:0]      i_cfg_data
);

    // compare width covers both the counter and the 16-bit period
    localparam int CMP_W = (COUNT_WIDTH > lfsd_pkg::PERIOD_W) ? COUNT_WIDTH
                                                              : lfsd_pkg::PERIOD_W;

    // configuration
    logic [lfsd_pkg::PERIOD_W-1:0] r_fast_period;
    logic [lfsd_pkg::PERIOD_W-1:0] r_slow_period;

    // motor state
    logic                          r_right_slow, r_left_slow;
    logic [COUNT_WIDTH-1:0]        r_right_count, r_left_count;
    logic [lfsd_pkg::PHASE_W-1:0]  r_right_phase, r_left_phase;
    logic [lfsd_pkg::COIL_W-1:0]   r_right_drive, r_left_drive;
    logic                          r_out_valid;

    // next values
    lfsd_pkg::t_motor_cmd          n_cmd;
    logic [COUNT_WIDTH-1:0]        n_right_count, n_left_count;
    logic [lfsd_pkg::PHASE_W-1:0]  n_right_phase, n_left_phase;
    logic [lfsd_pkg::COIL_W-1:0]   n_right_drive, n_left_drive;

    logic                          in_accept;
    logic [COUNT_WIDTH-1:0]        right_inc, left_inc;
    logic [lfsd_pkg::PERIOD_W-1:0] right_period, left_period;
    logic                          right_wrap, left_wrap;
    logic                          right_step, left_step;

    // output register frees up when its word is taken
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_accept   = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    // sensor decode; a speed not named by the pattern holds
    always_comb begin
        n_cmd.right_slow = r_right_slow;
        n_cmd.left_slow  = r_left_slow;
        unique case (i_sensor_pattern) inside
            lfsd_pkg::PAT_LEFT_HARD_A, lfsd_pkg::PAT_LEFT_HARD_B: begin
                n_cmd.right_en  = 1'b0;
                n_cmd.left_en   = 1'b1;
                n_cmd.left_slow = 1'b1;
            end
            lfsd_pkg::PAT_LEFT_SOFT_A, lfsd_pkg::PAT_LEFT_SOFT_B: begin
                n_cmd.right_en   = 1'b1;
                n_cmd.left_en    = 1'b1;
                n_cmd.right_slow = 1'b1;
                n_cmd.left_slow  = 1'b0;
            end
            lfsd_pkg::PAT_CENTER: begin
                n_cmd.right_en   = 1'b1;
                n_cmd.left_en    = 1'b1;
                n_cmd.right_slow = 1'b0;
                n_cmd.left_slow  = 1'b0;
            end
            lfsd_pkg::PAT_RIGHT_SOFT_A, lfsd_pkg::PAT_RIGHT_SOFT_B: begin
                n_cmd.right_en   = 1'b1;
                n_cmd.left_en    = 1'b1;
                n_cmd.right_slow = 1'b0;
                n_cmd.left_slow  = 1'b1;
            end
            lfsd_pkg::PAT_RIGHT_HARD_A, lfsd_pkg::PAT_RIGHT_HARD_B: begin
                n_cmd.right_en   = 1'b1;
                n_cmd.left_en    = 1'b0;
                n_cmd.right_slow = 1'b1;
            end
            default: begin
                // off the line: stop both
                n_cmd.right_en = 1'b0;
                n_cmd.left_en  = 1'b0;
            end
        endcase
    end

    // tick counters run on every accepted word, enabled or not; wrap when the period is reached
    assign right_period = n_cmd.right_slow ? r_slow_period : r_fast_period;
    assign left_period  = n_cmd.left_slow  ? r_slow_period : r_fast_period;
    assign right_inc    = r_right_count + 1'b1;
    assign left_inc     = r_left_count + 1'b1;
    assign right_wrap   = CMP_W'(right_inc) >= CMP_W'(right_period);
    assign left_wrap    = CMP_W'(left_inc)  >= CMP_W'(left_period);
    assign right_step   = right_wrap && n_cmd.right_en;
    assign left_step    = left_wrap && n_cmd.left_en;

    always_comb begin
        n_right_count = right_wrap ? '0 : right_inc;
        n_left_count  = left_wrap  ? '0 : left_inc;
        // phase advances before the table lookup
        n_right_phase = right_step ? r_right_phase + 1'b1 : r_right_phase;
        n_left_phase  = left_step  ? r_left_phase + 1'b1  : r_left_phase;
        n_right_drive = right_step ? lfsd_pkg::coil_of(n_right_phase) : r_right_drive;
        n_left_drive  = left_step  ? lfsd_pkg::coil_of(n_left_phase)  : r_left_drive;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fast_period <= lfsd_pkg::FAST_PERIOD_RST;
            r_slow_period <= lfsd_pkg::SLOW_PERIOD_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (lfsd_pkg::t_cfg_index'(i_cfg_index))
                lfsd_pkg::CFG_FAST_PERIOD: r_fast_period <= i_cfg_data;
                lfsd_pkg::CFG_SLOW_PERIOD: r_slow_period <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // motor state and output word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_right_slow  <= 1'b0;
            r_left_slow   <= 1'b0;
            r_right_count <= '0;
            r_left_count  <= '0;
            r_right_phase <= '0;
            r_left_phase  <= '0;
            r_right_drive <= lfsd_pkg::COIL_OFF;
            r_left_drive  <= lfsd_pkg::COIL_OFF;
            r_out_valid   <= 1'b0;
        end else begin
            if (in_accept) begin
                r_right_slow  <= n_cmd.right_slow;
                r_left_slow   <= n_cmd.left_slow;
                r_right_count <= n_right_count;
                r_left_count  <= n_left_count;
                r_right_phase <= n_right_phase;
                r_left_phase  <= n_left_phase;
                r_right_drive <= n_right_drive;
                r_left_drive  <= n_left_drive;
                r_out_valid   <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid   <= 1'b0;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_right_coils = r_right_drive;
    assign o_left_coils  = r_left_drive;

    // every accepted word yields a result in the next cycle
    a_accept_gives_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> o_out_valid)
        else $error("accepted sensor word produced no coil word");

    // a driven right coil always matches its phase
    a_right_drive_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_right_drive != lfsd_pkg::COIL_OFF) |->
            (r_right_drive == lfsd_pkg::coil_of(r_right_phase)))
        else $error("right coil drive out of step with its phase");

    // a driven left coil always matches its phase
    a_left_drive_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_left_drive != lfsd_pkg::COIL_OFF) |->
            (r_left_drive == lfsd_pkg::coil_of(r_left_phase)))
        else $error("left coil drive out of step with its phase");

    // a waiting coil word is not overwritten
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            ($stable(r_right_drive) && $stable(r_left_drive)))
        else $error("coil word changed while stalled");

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the line follower stepper drive
// ----------------------------------------------------------------------------
// Sensor words go in on a valid/ready channel and coil words come back on a
// second one. A behavioral copy of both steppers predicts every coil word at
// the sensor accept edge; the scoreboard pops the oldest prediction on each
// coil accept and compares it field by field. Directed words cover every
// sensor code, zero and full-scale periods and the first step after reset.
// Random traffic is mostly runs of legal codes with random periods, mixed
// with noise codes, under random gaps on both sides and one long output stall.
// ----------------------------------------------------------------------------
module tb_top;

    // timing and run control
    localparam int HALF_PERIOD  = 10;
    localparam int RESET_CYCLES = 5;
    localparam int MAX_IDLE     = 17;
    localparam int HOLD_CYCLES  = 300;
    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 10;
    localparam int CFG_SETTLE   = 3;

    // full-step sequence packed by phase, phase 0 in the low nibble
    localparam logic [4*lfsd_pkg::COIL_W-1:0] STEP_COILS = {
        lfsd_pkg::COIL_PH3, lfsd_pkg::COIL_PH2, lfsd_pkg::COIL_PH1, lfsd_pkg::COIL_PH0
    };

    // one motor: tick counter, phase and coil drive
    typedef struct packed {
        logic [lfsd_pkg::COUNT_WIDTH-1:0] count;
        logic [lfsd_pkg::PHASE_W-1:0]     phase;
        logic [lfsd_pkg::COIL_W-1:0]      drive;
    } t_stepper;

    // one predicted coil word
    typedef struct packed {
        logic [lfsd_pkg::COIL_W-1:0] right_coils;
        logic [lfsd_pkg::COIL_W-1:0] left_coils;
    } t_coil_word;

    // dut signals, all inputs known from time zero
    logic                            clk            = 1'b0;
    logic                            rst_n          = 1'b0;
    logic                            in_valid       = 1'b0;
    logic                            in_ready;
    logic [lfsd_pkg::SENSOR_W-1:0]   sensor_pattern = '0;
    logic                            out_valid;
    logic                            out_ready      = 1'b0;
    logic [lfsd_pkg::COIL_W-1:0]     right_coils;
    logic [lfsd_pkg::COIL_W-1:0]     left_coils;
    logic                            cfg_valid      = 1'b0;
    logic                            cfg_ready;
    lfsd_pkg::t_cfg_index            cfg_index      = lfsd_pkg::CFG_FAST_PERIOD;
    logic [lfsd_pkg::PERIOD_W-1:0]   cfg_data       = '0;

    // predictor state
    logic [lfsd_pkg::PERIOD_W-1:0]   fast_period    = lfsd_pkg::FAST_PERIOD_RST;
    logic [lfsd_pkg::PERIOD_W-1:0]   slow_period    = lfsd_pkg::SLOW_PERIOD_RST;
    logic                            right_on       = 1'b0;
    logic                            left_on        = 1'b0;
    logic                            right_slow     = 1'b0;
    logic                            left_slow      = 1'b0;
    t_stepper                        right_motor    = '0;
    t_stepper                        left_motor     = '0;

    // predicted coil words, oldest first
    t_coil_word             expected_coils[$];

    // run control shared between processes
    bit                     tx_idle        = 1'b1;
    bit                     rx_idle        = 1'b1;
    bit                     hold_request   = 1'b0;
    int                     mismatch_count = 0;
    int                     quiet_cycles   = 0;

    line_follower_stepper_drive i_dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_sensor_pattern (sensor_pattern),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .o_right_coils    (right_coils),
        .o_left_coils     (left_coils),
        .i_cfg_valid      (cfg_valid),
        .o_cfg_ready      (cfg_ready),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data)
    );

    initial begin
        forever #HALF_PERIOD clk = ~clk;
    end

    // one tick of one motor: count, compare with the period of its speed,
    // step the phase only when enabled
    function automatic t_stepper tick_stepper(t_stepper m, logic enabled, logic slow_speed);
        t_stepper                         s;
        logic [lfsd_pkg::PERIOD_W-1:0]    period;
        logic [lfsd_pkg::COUNT_WIDTH-1:0] count_up;
        s        = m;
        period   = slow_speed ? slow_period : fast_period;
        count_up = m.count + 1'b1;
        if (count_up >= period) begin
            // zero period lands here on every tick
            s.count = '0;
            if (enabled) begin
                s.phase = m.phase + 1'b1;
                s.drive = STEP_COILS[s.phase*lfsd_pkg::COIL_W +: lfsd_pkg::COIL_W];
            end
        end else begin
            s.count = count_up;
        end
        return s;
    endfunction

    // decode one sensor word into enables and speeds, then tick both motors
    function automatic t_coil_word predict_coils(logic [lfsd_pkg::SENSOR_W-1:0] pattern);
        t_coil_word w;
        case (pattern)
            lfsd_pkg::PAT_LEFT_HARD_A, lfsd_pkg::PAT_LEFT_HARD_B: begin
                right_on  = 1'b0;
                left_on   = 1'b1;
                left_slow = 1'b1;
            end
            lfsd_pkg::PAT_LEFT_SOFT_A, lfsd_pkg::PAT_LEFT_SOFT_B: begin
                right_on   = 1'b1;
                left_on    = 1'b1;
                right_slow = 1'b1;
                left_slow  = 1'b0;
            end
            lfsd_pkg::PAT_CENTER: begin
                right_on   = 1'b1;
                left_on    = 1'b1;
                right_slow = 1'b0;
                left_slow  = 1'b0;
            end
            lfsd_pkg::PAT_RIGHT_SOFT_A, lfsd_pkg::PAT_RIGHT_SOFT_B: begin
                right_on   = 1'b1;
                left_on    = 1'b1;
                right_slow = 1'b0;
                left_slow  = 1'b1;
            end
            lfsd_pkg::PAT_RIGHT_HARD_A, lfsd_pkg::PAT_RIGHT_HARD_B: begin
                right_on   = 1'b1;
                left_on    = 1'b0;
                right_slow = 1'b1;
            end
            default: begin
                // off the line: both stop, speeds held
                right_on = 1'b0;
                left_on  = 1'b0;
            end
        endcase
        right_motor   = tick_stepper(right_motor, right_on, right_slow);
        left_motor    = tick_stepper(left_motor, left_on, left_slow);
        w.right_coils = right_motor.drive;
        w.left_coils  = left_motor.drive;
        return w;
    endfunction

    // scoreboard: check coil words, predict on sensor words, track periods
    always @(posedge clk) begin : scoreboard
        t_coil_word oldest;
        if (rst_n) begin
            if (out_valid && out_ready) begin
                if (expected_coils.size() == 0) begin
                    $error("coil word with no prediction: right %h left %h",
                           right_coils, left_coils);
                    mismatch_count++;
                end else begin
                    oldest = expected_coils.pop_front();
                    if (right_coils !== oldest.right_coils) begin
                        $error("right_coils expected %h actual %h",
                               oldest.right_coils, right_coils);
                        mismatch_count++;
                    end
                    if (left_coils !== oldest.left_coils) begin
                        $error("left_coils expected %h actual %h",
                               oldest.left_coils, left_coils);
                        mismatch_count++;
                    end
                end
            end
            if (in_valid && in_ready) begin
                expected_coils.push_back(predict_coils(sensor_pattern));
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    lfsd_pkg::CFG_FAST_PERIOD: fast_period = cfg_data;
                    lfsd_pkg::CFG_SLOW_PERIOD: slow_period = cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // watchdog: too long without any accepted word ends the run
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // coil word receiver: random hold-off per word, or one long stall on request
    initial begin : coil_receiver
        int wait_cycles;
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                wait_cycles  = HOLD_CYCLES;
            end else begin
                wait_cycles = rx_idle ? $urandom_range(0, MAX_IDLE) : 0;
            end
            if (wait_cycles > 0) begin
                out_ready <= 1'b0;
                repeat (wait_cycles) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!(out_valid && out_ready));
        end
    end

    // send one sensor word, valid left high after the accept edge
    task automatic send_sensor_word(input logic [lfsd_pkg::SENSOR_W-1:0] pattern);
        int gap;
        gap = tx_idle ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        sensor_pattern <= pattern;
        do @(posedge clk); while (!in_ready);
    endtask

    // period write, only once every predicted coil word has come back
    task automatic write_period(input lfsd_pkg::t_cfg_index index,
                                input logic [lfsd_pkg::PERIOD_W-1:0] value);
        in_valid <= 1'b0;
        // the last sent word is on the queue by the next edge
        @(posedge clk);
        while (expected_coils.size() != 0) @(posedge clk);
        repeat (CFG_SETTLE) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic write_periods(input logic [lfsd_pkg::PERIOD_W-1:0] fast,
                                 input logic [lfsd_pkg::PERIOD_W-1:0] slow);
        write_period(lfsd_pkg::CFG_FAST_PERIOD, fast);
        write_period(lfsd_pkg::CFG_SLOW_PERIOD, slow);
    endtask

    // mostly small periods so the motors step often, with the extremes mixed in
    function automatic logic [lfsd_pkg::PERIOD_W-1:0] pick_period();
        int roll;
        int raw;
        roll = $urandom_range(0, 15);
        case (roll)
            0:       raw = 0;
            1:       raw = 65535;
            2:       raw = $urandom_range(0, 65535);
            3:       raw = $urandom_range(100, 400);
            default: raw = $urandom_range(1, 10);
        endcase
        return raw[lfsd_pkg::PERIOD_W-1:0];
    endfunction

    // runs of legal line codes with random lengths, plus short bursts of noise
    task automatic run_sensor_traffic(input int word_count);
        logic [lfsd_pkg::SENSOR_W-1:0] legal_codes [9];
        logic [lfsd_pkg::SENSOR_W-1:0] pattern;
        int                            sent;
        int                            run_len;
        int                            noise;
        legal_codes = '{lfsd_pkg::PAT_LEFT_HARD_A, lfsd_pkg::PAT_LEFT_HARD_B,
                        lfsd_pkg::PAT_LEFT_SOFT_A, lfsd_pkg::PAT_LEFT_SOFT_B,
                        lfsd_pkg::PAT_CENTER, lfsd_pkg::PAT_RIGHT_SOFT_A,
                        lfsd_pkg::PAT_RIGHT_SOFT_B, lfsd_pkg::PAT_RIGHT_HARD_A,
                        lfsd_pkg::PAT_RIGHT_HARD_B};
        sent = 0;
        while (sent < word_count) begin
            if ($urandom_range(0, 9) < 8) begin
                pattern = legal_codes[$urandom_range(0, 8)];
                run_len = $urandom_range(1, 24);
            end else begin
                noise   = $urandom_range(0, 31);
                pattern = noise[lfsd_pkg::SENSOR_W-1:0];
                run_len = $urandom_range(1, 3);
            end
            repeat (run_len) begin
                if (sent < word_count) begin
                    send_sensor_word(pattern);
                    sent++;
                end
            end
        end
    endtask

    // every sensor code once, plus off-line codes and held speeds
    task automatic test_pattern_decode();
        logic [lfsd_pkg::SENSOR_W-1:0] codes [15];
        write_periods(16'd1, 16'd2);
        codes = '{lfsd_pkg::PAT_CENTER, lfsd_pkg::PAT_LEFT_HARD_A,
                  lfsd_pkg::PAT_LEFT_HARD_B, lfsd_pkg::PAT_LEFT_SOFT_A,
                  lfsd_pkg::PAT_LEFT_SOFT_B, lfsd_pkg::PAT_RIGHT_SOFT_A,
                  lfsd_pkg::PAT_RIGHT_SOFT_B, lfsd_pkg::PAT_RIGHT_HARD_A,
                  lfsd_pkg::PAT_RIGHT_HARD_B, 5'b00000, 5'b11111,
                  5'b00101, 5'b01010, 5'b00111, 5'b11100};
        foreach (codes[k]) send_sensor_word(codes[k]);
    endtask

    // zero period: an enabled motor steps on every tick
    task automatic test_zero_period();
        write_periods(16'd0, 16'd0);
        send_sensor_word(lfsd_pkg::PAT_CENTER);
        send_sensor_word(lfsd_pkg::PAT_CENTER);
        send_sensor_word(lfsd_pkg::PAT_LEFT_HARD_B);
        send_sensor_word(lfsd_pkg::PAT_RIGHT_HARD_B);
        send_sensor_word(5'b00000);
    endtask

    // full-scale period: counters run but no step within a short burst
    task automatic test_full_period();
        write_periods(16'hFFFF, 16'hFFFF);
        send_sensor_word(lfsd_pkg::PAT_CENTER);
        send_sensor_word(lfsd_pkg::PAT_CENTER);
        send_sensor_word(lfsd_pkg::PAT_LEFT_SOFT_A);
        send_sensor_word(5'b11111);
    endtask

    // back to the power-on periods for a long run
    task automatic test_reset_periods();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        write_periods(lfsd_pkg::FAST_PERIOD_RST, lfsd_pkg::SLOW_PERIOD_RST);
        run_sensor_traffic(420);
    endtask

    // random periods per phase, each idling mix including none at all
    task automatic test_random_periods();
        for (int ph = 0; ph < 8; ph++) begin
            write_periods(pick_period(), pick_period());
            tx_idle = (ph % 4 == 0) || (ph % 4 == 2);
            rx_idle = (ph % 4 == 0) || (ph % 4 == 1);
            run_sensor_traffic(80);
        end
    endtask

    // long receiver stall while the sender keeps offering words
    task automatic test_output_backpressure();
        write_periods(16'd3, 16'd5);
        tx_idle      = 1'b0;
        rx_idle      = 1'b0;
        hold_request = 1'b1;
        run_sensor_traffic(60);
        rx_idle = 1'b1;
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // first step after reset is checked in the decode test
        test_pattern_decode();
        test_zero_period();
        test_full_period();
        test_reset_periods();
        test_random_periods();
        test_output_backpressure();

        // drain
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_coils.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
